// ===== sv/tco_pkg.sv =====
// ----------------------------------------------------------------------------
// tco_pkg
// types, constants and the one's complement adder shared by the checksum
// offload unit and its sub-blocks
// ----------------------------------------------------------------------------
`default_nettype none

package tco_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 8;

    localparam logic [15:0] PROTO_TCP = 16'd6;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDRESS   = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] segment_length;
    } t_out_beat;

    // one finished segment, handed from the front to the back
    typedef struct packed {
        logic [15:0] sum;
        logic [15:0] length;
    } t_seg_rec;

    // 16-bit add with end-around carry; the refold cannot carry again
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/tco_front.sv =====
// ----------------------------------------------------------------------------
// tco_front
// pairs segment bytes into words, keeps the running sum and byte count,
// and emits one record per segment on the last byte
// ----------------------------------------------------------------------------
`default_nettype none

module tco_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tco_pkg::t_in_beat i_in_data,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output tco_pkg::t_seg_rec      o_rec
);

    logic [15:0] r_sum,   n_sum;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_hi,    n_hi;
    logic        r_odd,   n_odd;

    logic        accept;
    logic [15:0] word;
    logic [15:0] sum_w;
    logic [15:0] count_inc;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // a trailing unpaired byte goes in high with a zero low byte
    assign word      = r_odd ? {r_hi, i_in_data.data_byte} : {i_in_data.data_byte, 8'h00};
    assign sum_w     = tco_pkg::oc_add(r_sum, word);
    assign count_inc = r_count + 16'd1;

    assign o_push       = accept && i_in_data.last_byte;
    assign o_rec.sum    = sum_w;
    assign o_rec.length = count_inc;

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_hi    = r_hi;
        n_odd   = r_odd;
        if (accept) begin
            if (i_in_data.last_byte) begin
                n_sum   = '0;
                n_count = '0;
                n_hi    = '0;
                n_odd   = 1'b0;
            end else if (r_odd) begin
                n_sum   = sum_w;
                n_count = count_inc;
                n_hi    = '0;
                n_odd   = 1'b0;
            end else begin
                n_count = count_inc;
                n_hi    = i_in_data.data_byte;
                n_odd   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_hi    <= '0;
            r_odd   <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_hi    <= n_hi;
            r_odd   <= n_odd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tco_queue.sv =====
// ----------------------------------------------------------------------------
// tco_queue
// short fifo of segment records between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module tco_queue #(
    parameter int DEPTH = tco_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tco_pkg::t_seg_rec i_rec,
    input  wire logic              i_pop,
    output tco_pkg::t_seg_rec      o_rec,
    output logic                   o_empty,
    output logic                   o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tco_pkg::t_seg_rec r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("record pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("record popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue fill count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count missed a push");
`endif

endmodule

`default_nettype wire

// ===== sv/tco_back.sv =====
// ----------------------------------------------------------------------------
// tco_back
// adds the pseudo-header to each segment record, inverts, and holds the
// result in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module tco_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tco_pkg::t_seg_rec i_rec,
    input  wire logic              i_q_empty,
    output logic                   o_pop,
    input  wire logic [31:0]       i_source_address,
    input  wire logic [31:0]       i_dest_address,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output tco_pkg::t_out_beat     o_out_data
);

    logic        r_a_vld;
    logic [15:0] r_p0, r_p1, r_p2, r_len;
    logic        r_o_vld;
    tco_pkg::t_out_beat r_out;

    logic        adv_o;
    logic        adv_a;
    logic [15:0] n_p0, n_p1, n_p2;
    logic [15:0] n_sum;

    assign adv_o = !r_o_vld || i_out_ready;
    assign adv_a = !r_a_vld || adv_o;
    assign o_pop = adv_a && !i_q_empty;

    // first level: three pairs of the seven words
    assign n_p0 = tco_pkg::oc_add(i_rec.sum, i_source_address[31:16]);
    assign n_p1 = tco_pkg::oc_add(i_source_address[15:0], i_dest_address[31:16]);
    assign n_p2 = tco_pkg::oc_add(i_dest_address[15:0], i_rec.length);

    // second level: the pairs and the protocol word
    assign n_sum = tco_pkg::oc_add(tco_pkg::oc_add(r_p0, r_p1),
                                   tco_pkg::oc_add(r_p2, tco_pkg::PROTO_TCP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_vld <= !i_q_empty;
            end
            if (adv_o) begin
                r_o_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_len <= i_rec.length;
        end
        if (adv_o) begin
            r_out.checksum       <= ~n_sum;
            r_out.segment_length <= r_len;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== sv/tcp_checksum_offload_unit.sv =====
// the record of a segment's accepted last byte passes the record queue, the pair registers and the output register
// throughput: one byte beat per cycle while the record queue is not full, with no gap between segments
// results leave at up to one per cycle; the two-entry record queue and the
// back pipeline let the byte side run on while results wait for the sink
// reset: synchronous active-low i_rst_n clears sums, counts, queue, valids and
// both address registers to zero; there is no clearing pass after reset
// ----------------------------------------------------------------------------
// tcp_checksum_offload_unit
// streaming tcp checksum with ipv4 pseudo-header over a byte stream
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_checksum_offload_unit #(
    parameter int QUEUE_DEPTH = tco_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // segment byte beats
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire tco_pkg::t_in_beat             i_in_data,
    // result beats
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output tco_pkg::t_out_beat                 o_out_data,
    // register writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tco_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    // pseudo-header addresses, network order
    logic [31:0] r_source_address;
    logic [31:0] r_dest_address;

    // record handoff between front and back
    tco_pkg::t_seg_rec push_rec;
    tco_pkg::t_seg_rec pop_rec;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;

    // register writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_address <= '0;
            r_dest_address   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tco_pkg::CFG_SOURCE_ADDRESS: r_source_address <= i_cfg_data;
                tco_pkg::CFG_DEST_ADDRESS:   r_dest_address   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: byte pairing, running sum and length count, one record per segment
    tco_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_rec      (push_rec)
    );

    // queue: decouples the byte stream from result back-pressure
    tco_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: pseudo-header add tree, inversion and output register
    tco_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec            (pop_rec),
        .i_q_empty        (q_empty),
        .o_pop            (pop),
        .i_source_address (r_source_address),
        .i_dest_address   (r_dest_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_data       (o_out_data)
    );

endmodule

`default_nettype wire
